>>> sv/plas_pkg.sv
// Shared types and constants for the polyline arc-length sampler.
package plas_pkg;

    // Item codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic CFG_ROUTE_LENGTH = 1'b0;
    localparam logic CFG_POINT_COUNT  = 1'b1;

    // Offset reported for routes with fewer than two points: 4 m in Q.8
    localparam logic [12:0] DEFAULT_OFFSET = 13'd1024;
    // Interpolation weight of one in Q.16
    localparam logic [16:0] T_ONE = 17'd65536;

    localparam int QUEUE_DEPTH = 2;

    // One input transaction as it travels from the front to the back
    typedef struct packed {
        logic               func;
        logic [9:0]         point_index;
        logic signed [23:0] point_x;
        logic signed [23:0] point_y;
        logic [23:0]        cum_distance;
        logic [12:0]        lane_offset;
        logic signed [24:0] query_distance;
    } t_item;

endpackage

>>> sv/plas_front.sv
// Front end: accepts transactions and holds them in a two-entry queue.
module plas_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  plas_pkg::t_item  i_item,
    output logic             o_valid,
    output plas_pkg::t_item  o_item,
    input  logic             i_ready
);
    import plas_pkg::*;

    t_item      r_slot [QUEUE_DEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_fill;
    logic       push;
    logic       pop;

    assign o_busy  = (r_fill == 2'(QUEUE_DEPTH));
    assign o_valid = (r_fill != 2'd0);
    assign o_item  = r_slot[r_rp];
    assign push    = i_start && !o_busy;
    assign pop     = o_valid && i_ready;

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= i_item;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

>>> sv/plas_back.sv
// Back end: route table, wrap divider, binary search, weight divider, interpolation.
module plas_back #(
    parameter int MAX_POINTS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  plas_pkg::t_item    i_item,
    output logic               o_ready,
    input  logic [23:0]        i_route_length,
    input  logic [10:0]        i_point_count,
    output logic               o_valid,
    output logic signed [23:0] o_pos_x,
    output logic signed [23:0] o_pos_y,
    output logic [12:0]        o_offset_out
);
    import plas_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_MOD, S_SRCH_I, S_SRCH_C, S_RD_A, S_RD_B, S_DIV, S_MUL, S_ADD
    } t_state;

    // Route table
    logic signed [23:0] x_mem [MAX_POINTS];
    logic signed [23:0] y_mem [MAX_POINTS];
    logic [23:0]        d_mem [MAX_POINTS];
    logic [12:0]        ofs_mem [MAX_POINTS];
    logic signed [23:0] r_rd_x;
    logic signed [23:0] r_rd_y;
    logic [23:0]        r_rd_d;
    logic [12:0]        r_rd_o;

    t_state             r_state;
    logic [CW-1:0]      r_cnt;
    logic [24:0]        r_rem;
    logic [24:0]        r_dvd;
    logic               r_neg;
    logic [4:0]         r_step;
    logic [23:0]        r_w;
    logic [CW-1:0]      r_first;
    logic [CW-1:0]      r_len;
    logic [AW-1:0]      r_idx;
    logic signed [23:0] r_x0, r_y0, r_x1, r_y1;
    logic [23:0]        r_d0;
    logic [12:0]        r_o0, r_o1;
    logic [23:0]        r_den;
    logic [16:0]        r_t;
    logic [1:0]         r_k;
    logic signed [42:0] r_prod;
    logic signed [23:0] r_px, r_py;

    logic               pop;
    logic               we;
    logic [AW-1:0]      wa;
    logic [AW-1:0]      ra;
    logic [CW-1:0]      cnt_sat;
    logic [CW-1:0]      mid;
    logic [CW-1:0]      fm1;
    logic [CW-1:0]      lim;
    logic [CW-1:0]      idx_full;
    logic [24:0]        q_abs;
    logic [24:0]        mod_try;
    logic [24:0]        mod_next;
    logic signed [24:0] span;
    logic signed [24:0] num;
    logic [24:0]        div_try;
    logic               div_ge;
    logic signed [24:0] diff;
    logic signed [24:0] base;
    logic signed [42:0] adj;
    logic signed [42:0] delta;
    logic signed [24:0] sum;

    assign o_ready = (r_state == S_IDLE);
    assign pop     = i_valid && o_ready;
    assign we      = pop && (i_item.func == FUNC_LOAD)
                     && (32'(i_item.point_index) < MAX_POINTS);
    assign wa      = AW'(i_item.point_index);
    assign cnt_sat = (32'(i_point_count) > MAX_POINTS) ? CW'(MAX_POINTS)
                                                        : CW'(i_point_count);

    // Search index and clamp to the last span
    assign mid      = r_first + (r_len >> 1);
    assign fm1      = (r_first == '0) ? '0 : r_first - CW'(1);
    assign lim      = r_cnt - CW'(2);
    assign idx_full = (fm1 > lim) ? lim : fm1;

    // Table read address
    always_comb begin
        case (r_state)
            S_SRCH_I: ra = (r_len == '0) ? idx_full[AW-1:0] : mid[AW-1:0];
            S_RD_A:   ra = r_idx + AW'(1);
            default:  ra = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            x_mem[wa]   <= i_item.point_x;
            y_mem[wa]   <= i_item.point_y;
            d_mem[wa]   <= i_item.cum_distance;
            ofs_mem[wa] <= i_item.lane_offset;
        end
        r_rd_x <= x_mem[ra];
        r_rd_y <= y_mem[ra];
        r_rd_d <= d_mem[ra];
        r_rd_o <= ofs_mem[ra];
    end

    // Wrap step: one quotient bit per cycle
    assign q_abs    = i_item.query_distance[24] ? 25'(-i_item.query_distance)
                                                : 25'(i_item.query_distance);
    assign mod_try  = {r_rem[23:0], r_dvd[24]};
    assign mod_next = (mod_try >= {1'b0, i_route_length})
                      ? mod_try - {1'b0, i_route_length} : mod_try;

    // Span and numerator of the weight
    assign span = $signed({1'b0, r_rd_d}) - $signed({1'b0, r_d0});
    assign num  = $signed({1'b0, r_w}) - $signed({1'b0, r_d0});

    // Weight step: one fraction bit per cycle
    assign div_try = {r_rem[23:0], 1'b0};
    assign div_ge  = (div_try >= {1'b0, r_den});

    // Interpolation operands
    always_comb begin
        case (r_k)
            2'd0: begin
                diff = 25'(r_x1) - 25'(r_x0);
                base = 25'(r_x0);
            end
            2'd1: begin
                diff = 25'(r_y1) - 25'(r_y0);
                base = 25'(r_y0);
            end
            default: begin
                diff = $signed({12'd0, r_o1}) - $signed({12'd0, r_o0});
                base = $signed({12'd0, r_o0});
            end
        endcase
    end

    // Quotient by 65536 truncated toward zero
    assign adj   = r_prod[42] ? r_prod + 43'sd65535 : r_prod;
    assign delta = adj >>> 16;
    assign sum   = base + delta[24:0];

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (pop && (i_item.func == FUNC_QUERY)) begin
                        r_cnt   <= cnt_sat;
                        r_first <= '0;
                        r_len   <= cnt_sat;
                        r_rem   <= '0;
                        r_dvd   <= q_abs;
                        r_neg   <= i_item.query_distance[24];
                        r_step  <= '0;
                        r_w     <= '0;
                        if (cnt_sat < CW'(2)) begin
                            r_state <= S_RD0;
                        end else if (i_route_length == '0) begin
                            r_state <= S_SRCH_I;
                        end else begin
                            r_state <= S_MOD;
                        end
                    end
                end
                S_RD0: begin
                    o_pos_x      <= (r_cnt == CW'(1)) ? r_rd_x : '0;
                    o_pos_y      <= (r_cnt == CW'(1)) ? r_rd_y : '0;
                    o_offset_out <= DEFAULT_OFFSET;
                    o_valid      <= 1'b1;
                    r_state      <= S_IDLE;
                end
                S_MOD: begin
                    r_rem  <= mod_next;
                    r_dvd  <= {r_dvd[23:0], 1'b0};
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd24) begin
                        if (r_neg && (mod_next != '0)) begin
                            r_w <= 24'({1'b0, i_route_length} - mod_next);
                        end else begin
                            r_w <= mod_next[23:0];
                        end
                        r_state <= S_SRCH_I;
                    end
                end
                S_SRCH_I: begin
                    if (r_len == '0) begin
                        r_idx   <= idx_full[AW-1:0];
                        r_state <= S_RD_A;
                    end else begin
                        r_state <= S_SRCH_C;
                    end
                end
                S_SRCH_C: begin
                    if (r_w < r_rd_d) begin
                        r_len <= r_len >> 1;
                    end else begin
                        r_first <= mid + CW'(1);
                        r_len   <= r_len - (r_len >> 1) - CW'(1);
                    end
                    r_state <= S_SRCH_I;
                end
                S_RD_A: begin
                    r_x0    <= r_rd_x;
                    r_y0    <= r_rd_y;
                    r_d0    <= r_rd_d;
                    r_o0    <= r_rd_o;
                    r_state <= S_RD_B;
                end
                S_RD_B: begin
                    r_x1   <= r_rd_x;
                    r_y1   <= r_rd_y;
                    r_o1   <= r_rd_o;
                    r_den  <= span[23:0];
                    r_rem  <= {1'b0, num[23:0]};
                    r_step <= '0;
                    r_k    <= 2'd0;
                    if ((span <= 0) || (num <= 0)) begin
                        r_t     <= '0;
                        r_state <= S_MUL;
                    end else if (num >= span) begin
                        r_t     <= T_ONE;
                        r_state <= S_MUL;
                    end else begin
                        r_t     <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= div_ge ? div_try - {1'b0, r_den} : div_try;
                    r_t    <= {r_t[15:0], div_ge};
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd15) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= diff * $signed({1'b0, r_t});
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_k <= r_k + 2'd1;
                    case (r_k)
                        2'd0: begin
                            r_px    <= sum[23:0];
                            r_state <= S_MUL;
                        end
                        2'd1: begin
                            r_py    <= sum[23:0];
                            r_state <= S_MUL;
                        end
                        default: begin
                            o_pos_x      <= r_px;
                            o_pos_y      <= r_py;
                            o_offset_out <= sum[12:0];
                            o_valid      <= 1'b1;
                            r_state      <= S_IDLE;
                        end
                    endcase
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> sv/polyline_arc_length_sampler.sv
// Top level of the polyline arc-length sampler: config registers, front queue, back end.
// Usage:
//   Input channel: raise i_start with the item fields; the transaction is taken on a
//   clock edge where i_start is high and o_busy is low. i_func selects a table load
//   (point written at i_point_index) or a position query at i_query_distance.
//   Output channel: o_valid pulses for one cycle with o_pos_x, o_pos_y and
//   o_offset_out; a query gives one result, a load gives none. The receiver cannot
//   stall, so results are never held back.
//   Config: write route length (index 0) or point count (index 1) with i_cfg_we,
//   only while no transaction is in flight.
// Sequencing:
//   A two-entry queue decouples input from the sequencer, which handles one item at
//   a time; o_busy is high while both entries are taken. A load is written to the
//   table when the sequencer takes it, and the sequencer stays idle. A query with fewer
//   than two points passes through S_RD0, which strobes its result. Otherwise: dispatch,
//   wrap division (skipped for route length 0), binary search (at most
//   floor(log2(count))+1 steps, one read port), closing the search and reading the span,
//   weight division (skipped for weight 0 or one), interpolation on a shared multiplier.
// Reset: clears the queue, sequencer and both config registers; table contents are
//   undefined until loaded.
module polyline_arc_length_sampler #(
    parameter int MAX_POINTS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic               i_func,
    input  logic [9:0]         i_point_index,
    input  logic signed [23:0] i_point_x,
    input  logic signed [23:0] i_point_y,
    input  logic [23:0]        i_cum_distance,
    input  logic [12:0]        i_lane_offset,
    input  logic signed [24:0] i_query_distance,
    output logic               o_valid,
    output logic signed [23:0] o_pos_x,
    output logic signed [23:0] o_pos_y,
    output logic [12:0]        o_offset_out,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [23:0]        i_cfg_data
);
    import plas_pkg::*;

    logic [23:0] r_route_length;
    logic [10:0] r_point_count;
    t_item       in_item;
    t_item       q_item;
    logic        q_valid;
    logic        q_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_route_length <= '0;
            r_point_count  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROUTE_LENGTH: r_route_length <= i_cfg_data;
                CFG_POINT_COUNT:  r_point_count  <= i_cfg_data[10:0];
                default:          r_route_length <= r_route_length;
            endcase
        end
    end

    // Pack input fields
    always_comb begin
        in_item.func           = i_func;
        in_item.point_index    = i_point_index;
        in_item.point_x        = i_point_x;
        in_item.point_y        = i_point_y;
        in_item.cum_distance   = i_cum_distance;
        in_item.lane_offset    = i_lane_offset;
        in_item.query_distance = i_query_distance;
    end

    plas_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .i_item  (in_item),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_ready (q_ready)
    );

    plas_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .i_item         (q_item),
        .o_ready        (q_ready),
        .i_route_length (r_route_length),
        .i_point_count  (r_point_count),
        .o_valid        (o_valid),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_offset_out   (o_offset_out)
    );

endmodule
